[rtl/core/wfd_pkg.sv]
// Shared types and codes for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wfd_pkg;

  // Parse phases of the receive side.
  typedef enum logic [2:0] {
    PH_B0  = 3'd0,
    PH_B1  = 3'd1,
    PH_EXT = 3'd2,
    PH_KEY = 3'd3,
    PH_PAY = 3'd4
  } phase_e;

  // Event codes carried on event_res.
  localparam logic [2:0] EV_MSG    = 3'd0;
  localparam logic [2:0] EV_PING   = 3'd1;
  localparam logic [2:0] EV_CLOSE  = 3'd2;
  localparam logic [2:0] EV_BADOP  = 3'd3;
  localparam logic [2:0] EV_BADLEN = 3'd4;

  // Opcodes that need special handling.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Short length codes that announce an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // One result beat.
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } res_t;

endpackage

[rtl/core/wfd_parser.sv]
// Header parser and payload unmasker: one received byte per cycle while accept_i is high.
`timescale 1ns / 1ps

module wfd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          res_valid_o,
  output wfd_pkg::res_t res_o
);
  import wfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic        final_q, final_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [7:0]  key_q [4];
  logic [7:0]  key_d [4];
  logic [1:0]  pos_q, pos_d;
  logic        bad_q, bad_d;
  logic        do_finish;
  logic        pay_end;
  logic [7:0]  pay_val;

  function automatic logic is_data_op(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
  endfunction

  // Next state and result for the byte being taken.
  always_comb begin
    phase_d     = phase_q;
    hc_d        = hc_q;
    final_d     = final_q;
    op_d        = op_q;
    masked_d    = masked_q;
    rem_d       = rem_q;
    key_d       = key_q;
    pos_d       = pos_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    do_finish   = 1'b0;
    pay_val     = rx_byte_i ^ key_q[pos_q];
    pay_end     = (rem_q == 64'd1);

    if (accept_i && !bad_q) begin
      case (phase_q)
        PH_B1: begin
          masked_d = rx_byte_i[7];
          if (!rx_byte_i[7]) begin
            key_d = '{default: 8'h00};
          end
          if (rx_byte_i[6:0] < LEN_EXT16) begin
            rem_d = {57'd0, rx_byte_i[6:0]};
            if (rx_byte_i[7]) begin
              phase_d = PH_KEY;
              hc_d    = 4'd4;
            end else begin
              do_finish = 1'b1;
            end
          end else begin
            rem_d   = '0;
            hc_d    = (rx_byte_i[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
            phase_d = PH_EXT;
          end
        end
        PH_EXT: begin
          rem_d = {rem_q[55:0], rx_byte_i};
          hc_d  = hc_q - 4'd1;
          if (hc_q == 4'd1) begin
            if (masked_q) begin
              phase_d = PH_KEY;
              hc_d    = 4'd4;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_d[2'd0 - hc_q[1:0]] = rx_byte_i;
          hc_d = hc_q - 4'd1;
          if (hc_q == 4'd1) begin
            do_finish = 1'b1;
          end
        end
        PH_PAY: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - 64'd1;
          if (pay_end) begin
            phase_d = PH_B0;
          end
          if (is_data_op(op_q)) begin
            res_valid_o = 1'b1;
            res_o = '{event_res: EV_MSG, data: pay_val, has_data: 1'b1,
                      last: pay_end && final_q};
          end else if (op_q == OP_PING) begin
            res_valid_o = 1'b1;
            res_o = '{event_res: EV_PING, data: pay_val, has_data: 1'b1, last: pay_end};
          end else if (op_q != OP_PONG && pay_end) begin
            // Close and unknown opcodes report once, at the end of the frame.
            res_valid_o     = 1'b1;
            res_o.event_res = (op_q == OP_CLOSE) ? EV_CLOSE : EV_BADOP;
          end
        end
        default: begin
          final_d = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_B1;
        end
      endcase

      // Header complete: check the length and pick the payload or frame end.
      if (do_finish) begin
        pos_d = '0;
        hc_d  = '0;
        if (rem_d[63]) begin
          bad_d           = 1'b1;
          phase_d         = PH_B0;
          res_valid_o     = 1'b1;
          res_o.event_res = EV_BADLEN;
        end else if (rem_d == 64'd0) begin
          phase_d = PH_B0;
          if (is_data_op(op_q)) begin
            res_valid_o = final_q;
            res_o.event_res = EV_MSG;
            res_o.last      = 1'b1;
          end else if (op_q == OP_PING) begin
            res_valid_o     = 1'b1;
            res_o.event_res = EV_PING;
            res_o.last      = 1'b1;
          end else if (op_q != OP_PONG) begin
            res_valid_o     = 1'b1;
            res_o.event_res = (op_q == OP_CLOSE) ? EV_CLOSE : EV_BADOP;
          end
        end else begin
          phase_d = PH_PAY;
        end
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      hc_q     <= '0;
      final_q  <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      key_q    <= '{default: 8'h00};
      pos_q    <= '0;
      bad_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hc_q     <= hc_d;
      final_q  <= final_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      bad_q    <= bad_d;
    end
  end

endmodule

[rtl/core/wfd_obuf.sv]
// Result register with a skid stage so the parser keeps taking bytes.
`timescale 1ns / 1ps

module wfd_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wfd_pkg::res_t push_res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wfd_pkg::res_t out_res_o
);
  import wfd_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic slot_free;

  // The output slot frees when it is empty or its beat leaves now.
  always_comb begin
    slot_free    = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (slot_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (slot_free) begin
        out_d       = push_res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_res_i;
        skid_valid_d = 1'b1;
      end
    end else if (slot_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags are control; payload registers take no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

[rtl/core/websocket_frame_deframer_top.sv]
// Top level of the WebSocket receive-side frame deframer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i| event_res_o data_o has_data_o last_o
//
// One byte is taken per cycle while in_stall_o is low; its result, if any, is registered in
// the result register, or in the skid stage while the output is stalled. The rate is set by
// the parse update of the 64-bit remaining-length counter. A skid stage behind the result
// register holds one extra beat, so in_stall_o rises only when both are full. Reset clears
// the parse state and both valid flags at once; no clearing pass follows.
`timescale 1ns / 1ps

module websocket_frame_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] data_o,
  output logic       has_data_o,
  output logic       last_o
);
  import wfd_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Parse and unmask the incoming beat.
  wfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register the result and absorb output stalls.
  wfd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign event_res_o = out_res.event_res;
  assign data_o      = out_res.data;
  assign has_data_o  = out_res.has_data;
  assign last_o      = out_res.last;

endmodule

[rtl/core/wfd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps

module wfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] event_res_o,
  input logic [7:0] data_o,
  input logic       has_data_o,
  input logic       last_o
);
  import wfd_pkg::*;

  // A stalled output beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({event_res_o, data_o, has_data_o, last_o}))
    else $error("output beat changed while stalled");

  // Markers and events carry a zero data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> data_o == 8'h00)
    else $error("data set on a beat without payload");

  // Close, bad opcode and bad length beats carry neither data nor last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_CLOSE || event_res_o == EV_BADOP ||
                    event_res_o == EV_BADLEN) |-> !has_data_o && !last_o)
    else $error("event beat carries data or last");

  // A delivered bad-length report is the final beat until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && event_res_o == EV_BADLEN |=> !out_valid_o)
    else $error("beat delivered after a bad length report");

endmodule

bind websocket_frame_deframer_top wfd_checker u_wfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o),
  .data_o      (data_o),
  .has_data_o  (has_data_o),
  .last_o      (last_o)
);

[tb/websocket_frame_deframer_top_tb.sv]
// Self-checking testbench for the WebSocket receive-side frame deframer.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wfd_pkg::*;

  // Run shape.
  localparam int RandomStop  = 1725;
  localparam int QuietAt     = 1450;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 12;
  localparam int LongHold    = 80;
  localparam int HoldAfter   = 300;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_WANT
  } check_e;

  typedef struct packed {
    logic [7:0] b;
    check_e     chk;
    res_t       want;
  } step_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] event_res_o;
  logic [7:0] data_o;
  logic       has_data_o;
  logic       last_o;

  websocket_frame_deframer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .data_o      (data_o),
    .has_data_o  (has_data_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframer state as the testbench tracks it.
  phase_e      rx_phase;
  logic [3:0]  hdr_left;
  logic        frm_fin;
  logic [3:0]  frm_op;
  logic        frm_masked;
  logic [63:0] pay_left;
  logic [7:0]  key_bytes [4];
  logic [1:0]  key_pos;
  logic        rx_dead;

  res_t  expected_beats[$];
  step_t directed_steps[$];
  res_t  want_beat;
  int    tail_at;
  int    sent_cnt = 0;
  int    results_seen = 0;
  int    mismatch_cnt = 0;
  bit    quiet = 1'b0;
  bit    send_calm = 1'b0;

  function automatic bit is_msg_op(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BIN;
  endfunction

  // Event that a close or unknown opcode gives when its frame ends; a pong gives none.
  function automatic bit control_end(output res_t r);
    r = '0;
    if (frm_op == OP_PONG) return 1'b0;
    r.event_res = (frm_op == OP_CLOSE) ? EV_CLOSE : EV_BADOP;
    return 1'b1;
  endfunction

  // Header complete: check the length, then either end an empty frame or go to payload.
  function automatic bit header_done(output res_t r);
    r = '0;
    key_pos  = 2'd0;
    hdr_left = 4'd0;
    if (pay_left[63]) begin
      rx_dead = 1'b1;
      rx_phase = PH_B0;
      r.event_res = EV_BADLEN;
      return 1'b1;
    end
    if (pay_left == 64'd0) begin
      rx_phase = PH_B0;
      if (is_msg_op(frm_op)) begin
        r.last = 1'b1;
        return frm_fin;
      end
      if (frm_op == OP_PING) begin
        r.event_res = EV_PING;
        r.last = 1'b1;
        return 1'b1;
      end
      return control_end(r);
    end
    rx_phase = PH_PAY;
    return 1'b0;
  endfunction

  function automatic bit length_done(output res_t r);
    r = '0;
    if (frm_masked) begin
      rx_phase = PH_KEY;
      hdr_left = 4'd4;
      return 1'b0;
    end
    return header_done(r);
  endfunction

  // Advances the tracked state by one received byte; returns 1 when a result beat is due.
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    logic [3:0] slot;
    logic [7:0] plain;
    logic       at_end;
    r = '0;
    if (rx_dead) return 1'b0;
    case (rx_phase)
      PH_B1: begin
        frm_masked = b[7];
        if (!b[7]) begin
          key_bytes[0] = 8'h00;
          key_bytes[1] = 8'h00;
          key_bytes[2] = 8'h00;
          key_bytes[3] = 8'h00;
        end
        pay_left = 64'd0;
        if (b[6:0] < LEN_EXT16) begin
          pay_left = {57'd0, b[6:0]};
          return length_done(r);
        end
        hdr_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
        rx_phase = PH_EXT;
        return 1'b0;
      end
      PH_EXT: begin
        pay_left = {pay_left[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) return length_done(r);
        return 1'b0;
      end
      PH_KEY: begin
        slot = 4'd4 - hdr_left;
        key_bytes[slot[1:0]] = b;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) return header_done(r);
        return 1'b0;
      end
      PH_PAY: begin
        plain = b ^ key_bytes[key_pos];
        key_pos = key_pos + 2'd1;
        pay_left = pay_left - 64'd1;
        at_end = (pay_left == 64'd0);
        if (at_end) rx_phase = PH_B0;
        if (is_msg_op(frm_op)) begin
          r.event_res = EV_MSG;
          r.data = plain;
          r.has_data = 1'b1;
          r.last = at_end & frm_fin;
          return 1'b1;
        end
        if (frm_op == OP_PING) begin
          r.event_res = EV_PING;
          r.data = plain;
          r.has_data = 1'b1;
          r.last = at_end;
          return 1'b1;
        end
        if (!at_end) return 1'b0;
        return control_end(r);
      end
      default: begin
        frm_fin = b[7];
        frm_op = b[3:0];
        rx_phase = PH_B1;
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one byte, with an occasional idle burst ahead of it, and waits until it is taken.
  task automatic offer_byte(input logic [7:0] b, output bit got, output res_t r);
    int gap;
    if (!quiet && $urandom_range(0, 149) == 0) send_calm = !send_calm;
    gap = 0;
    if (!quiet && !send_calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = deframe_byte(b, r);
    sent_cnt++;
    if (sent_cnt >= QuietAt) quiet = 1'b1;
  endtask

  task automatic feed(input logic [7:0] b);
    bit   got;
    res_t r;
    offer_byte(b, got, r);
    if (got) expected_beats.push_back(r);
  endtask

  // Directed table entries.
  task automatic row_none(input logic [7:0] b);
    directed_steps.push_back({b, CHK_NONE, 13'd0});
  endtask

  task automatic row_model(input logic [7:0] b);
    directed_steps.push_back({b, CHK_MODEL, 13'd0});
  endtask

  task automatic row_want(input logic [7:0] b, input logic [2:0] ev, input logic [7:0] d,
                          input logic hd, input logic lst);
    directed_steps.push_back({b, CHK_WANT, ev, d, hd, lst});
  endtask

  task automatic play_rows(input int lo, input int hi);
    bit   got;
    res_t r;
    for (int i = lo; i < hi; i++) begin
      offer_byte(directed_steps[i].b, got, r);
      case (directed_steps[i].chk)
        CHK_MODEL: if (got) expected_beats.push_back(r);
        CHK_WANT:  expected_beats.push_back(directed_steps[i].want);
        default:   ;
      endcase
    end
  endtask

  // One frame with random opcode, FIN, reserved bits, mask, length encoding, key and payload.
  task automatic random_frame();
    int          pick;
    int          len;
    int          enc;
    logic [3:0]  op;
    logic [2:0]  rsv;
    logic        fin;
    logic        mbit;
    logic [63:0] len64;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = 4'($urandom_range(0, 2));
    else if (pick < 60) op = OP_PING;
    else if (pick < 68) op = OP_CLOSE;
    else if (pick < 78) op = OP_PONG;
    else                op = 4'($urandom_range(0, 15));
    fin  = ($urandom_range(0, 3) != 0);
    mbit = 1'($urandom_range(0, 1));
    rsv  = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = $urandom_range(0, 12);
    else if (pick < 93) len = $urandom_range(13, 60);
    else                len = $urandom_range(126, 300);
    // Lengths under 126 sometimes take a non-minimal extended encoding.
    if (len > 125) begin
      enc = $urandom_range(1, 2);
    end else begin
      pick = $urandom_range(0, 9);
      enc = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
    end
    len64 = 64'(len);
    feed({fin, rsv, op});
    case (enc)
      0: feed({mbit, len64[6:0]});
      1: begin
        feed({mbit, LEN_EXT16});
        feed(len64[15:8]);
        feed(len64[7:0]);
      end
      default: begin
        feed({mbit, LEN_EXT64});
        for (int i = 7; i >= 0; i--) feed(len64[i*8 +: 8]);
      end
    endcase
    if (mbit) repeat (4) feed(8'($urandom_range(0, 255)));
    repeat (len) feed(8'($urandom_range(0, 255)));
  endtask

  // Stimulus and end of run.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = 8'h00;
    rx_phase = PH_B0;
    hdr_left = 4'd0;
    frm_fin = 1'b0;
    frm_op = 4'd0;
    frm_masked = 1'b0;
    pay_left = 64'd0;
    key_bytes[0] = 8'h00;
    key_bytes[1] = 8'h00;
    key_bytes[2] = 8'h00;
    key_bytes[3] = 8'h00;
    key_pos = 2'd0;
    rx_dead = 1'b0;

    // Empty final text frame gives a bare marker.
    row_none(8'h81);
    row_want(8'h00, EV_MSG, 8'h00, 1'b0, 1'b1);
    // Empty non-final binary frame gives nothing.
    row_none(8'h02);
    row_none(8'h00);
    // Empty ping gives a ping marker.
    row_none(8'h89);
    row_want(8'h00, EV_PING, 8'h00, 1'b0, 1'b1);
    // Empty close is reported at once.
    row_none(8'h88);
    row_want(8'h00, EV_CLOSE, 8'h00, 1'b0, 1'b0);
    // All-ones header byte: final, reserved opcode 15, reported when its payload ends.
    row_none(8'hFF);
    row_none(8'h01);
    row_want(8'hFF, EV_BADOP, 8'h00, 1'b0, 1'b0);
    // Masked one-byte ping.
    row_none(8'h89);
    row_none(8'h81);
    row_none(8'h5A);
    row_none(8'h00);
    row_none(8'h00);
    row_none(8'h00);
    row_want(8'hFF, EV_PING, 8'hA5, 1'b1, 1'b1);
    // Unmasked non-final text with a non-minimal 16-bit length, then an empty final fragment.
    row_none(8'h01);
    row_none(8'h7E);
    row_none(8'h00);
    row_none(8'h02);
    row_model(8'h12);
    row_model(8'h34);
    row_none(8'h80);
    row_want(8'h00, EV_MSG, 8'h00, 1'b0, 1'b1);
    tail_at = directed_steps.size();
    // Masked 64-bit length with the top bit set: reported after the key, then silence.
    row_none(8'h82);
    row_none(8'hFF);
    row_none(8'h80);
    repeat (7) row_none(8'h00);
    row_none(8'h11);
    row_none(8'h22);
    row_none(8'h33);
    row_want(8'h44, EV_BADLEN, 8'h00, 1'b0, 1'b0);
    row_none(8'h81);
    row_none(8'h00);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    play_rows(0, tail_at);
    while (sent_cnt < RandomStop) random_frame();
    play_rows(tail_at, directed_steps.size());
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stall bursts, calm stretches, and one long hold to back up the input.
  initial begin
    int  hold_left;
    bit  held_long;
    bit  rcv_calm;
    hold_left = 0;
    held_long = 1'b0;
    rcv_calm = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    while (!quiet) begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) rcv_calm = !rcv_calm;
      if (hold_left == 0) begin
        if (!held_long && results_seen >= HoldAfter) begin
          held_long = 1'b1;
          hold_left = LongHold;
        end else if (!rcv_calm && $urandom_range(0, 9) == 0) begin
          hold_left = $urandom_range(1, 18);
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    out_stall_i <= 1'b0;
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("beat %0d unexpected: event %0d data %02h has_data %0d last %0d",
                   results_seen, event_res_o, data_o, has_data_o, last_o);
      end else begin
        want_beat = expected_beats.pop_front();
        if (want_beat.event_res !== event_res_o || want_beat.data !== data_o ||
            want_beat.has_data !== has_data_o || want_beat.last !== last_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("beat %0d: expected event %0d data %02h has_data %0d last %0d, ",
                   results_seen, want_beat.event_res, want_beat.data, want_beat.has_data,
                   want_beat.last);
            $display("got event %0d data %02h has_data %0d last %0d",
                     event_res_o, data_o, has_data_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat moving on either side.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
